FILE: design/u2h_pkg.sv
// Package for the UTF-8 to HTML entity rewriter.
// Shared types and constants; no dependencies.
package u2h_pkg;
   localparam int NAME_OUT_MAX = 15;
   // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_NAME  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_EMIT  = 6'b001000,
      ST_RDWT  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   typedef struct packed {
      logic       start;
      logic [30:0] value;
   } div_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [3:0]  digit;
      logic        zero;
      logic [30:0] quot;
   } div_sts_type;
endpackage

FILE: design/u2h_if.sv
// Valid/ready channel interface carrying a payload word.
// Depends on nothing.
interface u2h_if #(parameter int W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/u2h_div10.sv
// Shared divide-by-ten unit: reciprocal multiply, then remainder.
// Uses u2h_pkg control and status structs.
module u2h_div10 (
   input  logic                 clock,
   input  logic                 reset,
   input  u2h_pkg::div_ctl_type ctl,
   output u2h_pkg::div_sts_type sts
);
   logic [30:0] val_ff, val_in;
   logic [30:0] quo_ff, quo_in;
   logic [3:0]  rem_ff, rem_in;
   logic        busy_ff, busy_in, phase_ff, phase_in, done_ff, done_in;
   logic [62:0] prod;
   logic [30:0] back;

   always_comb begin
      val_in   = val_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      prod     = 63'(val_ff) * 63'(u2h_pkg::RECIP10);
      back     = val_ff - ({quo_ff[27:0], 3'd0} + {quo_ff[29:0], 1'b0});
      if (ctl.start) begin
         val_in   = ctl.value;
         busy_in  = 1'b1;
         phase_in = 1'b0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            quo_in   = 31'(prod[62:35]);
            phase_in = 1'b1;
         end else begin
            rem_in  = back[3:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign sts.digit = rem_ff;
   assign sts.zero  = (quo_ff == 31'd0);
   assign sts.quot  = quo_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < 4'd10) else $error("bad digit");
endmodule

FILE: design/utf8_to_html_entity_rewriter_core.sv
// Top level of the UTF-8 to HTML entity rewriter.
// Depends on u2h_pkg, u2h_if and u2h_div10.
//
// Channel  Dir  Word
// req      in   action, data_byte, last_byte, entity_code, name_pos
// rsp      out  out_byte, last_of_run, stream_changed
//
// Each request word is taken in ST_IDLE and its output bytes then leave through
// ST_EMIT; a named entity reads and appends each name character in turn
// (ST_RDWT, then ST_NAME) and then closes it with ';'; a decimal reference
// follows a failed name check and runs the shared divider once per digit.
// The name store is cleared over all ENTITY_COUNT*NAME_LEN entries after
// reset; req is held off meanwhile. rsp stalls hold the sequencer in place.
module utf8_to_html_entity_rewriter_core #(
   parameter int ENTITY_COUNT = 16384,
   parameter int NAME_LEN     = 16
) (
   input logic clock,
   input logic reset,
   u2h_if.sink   req,
   u2h_if.source rsp
);
   localparam int DEPTH = ENTITY_COUNT * NAME_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int NMAX  = (NAME_LEN - 1) < u2h_pkg::NAME_OUT_MAX ?
                          (NAME_LEN - 1) : u2h_pkg::NAME_OUT_MAX;

   logic       req_action, req_last;
   logic [7:0] req_data;
   logic [13:0] req_code;
   logic [3:0] req_pos;
   assign {req_action, req_data, req_last, req_code, req_pos} = req.payload;

   logic [7:0] names [DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic       wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0] wr_data;
   logic [AW:0] clr_ff, clr_in;

   u2h_pkg::state_type state_ff, state_in;
   logic       tag_ff, tag_in, chg_ff, chg_in;
   logic [7:0] held_ff [5];
   logic [7:0] held_in [5];
   logic [2:0] hcnt_ff, hcnt_in, slen_ff, slen_in;
   logic [30:0] acc_ff, acc_in;
   // output queue of up to 17 bytes
   logic [7:0] q_ff [17];
   logic [7:0] q_in [17];
   logic [4:0] qn_ff, qn_in, qi_ff, qi_in;
   logic       last_ff, last_in;
   logic [30:0] cp_ff, cp_in;
   logic [3:0] dn_ff, dn_in, ni_ff, ni_in;
   logic [7:0] dig_ff [10];
   logic [7:0] dig_in [10];
   u2h_pkg::div_ctl_type dctl;
   u2h_pkg::div_sts_type dsts;

   u2h_div10 u_div (.clock(clock), .reset(reset), .ctl(dctl), .sts(dsts));

   logic clearing;
   assign clearing = (clr_ff != (AW+1)'(DEPTH));
   assign req.ready = (state_ff == u2h_pkg::ST_IDLE) && !clearing;
   logic take;
   assign take = req.valid && req.ready;

   assign rsp.valid   = (state_ff == u2h_pkg::ST_EMIT);
   assign rsp.payload = {q_ff[qi_ff], (qi_ff == qn_ff - 5'd1), chg_ff};

   assign rd_addr = AW'(cp_ff[AW-1:0] * NAME_LEN) + AW'(ni_ff);

   always_comb begin
      logic [4:0] n;
      logic [7:0] b;
      logic [2:0] hc;
      logic [30:0] cp;
      logic       emit;
      state_in = state_ff;
      tag_in = tag_ff; chg_in = chg_ff; hcnt_in = hcnt_ff; slen_in = slen_ff;
      acc_in = acc_ff; held_in = held_ff; q_in = q_ff; qn_in = qn_ff;
      qi_in = qi_ff; last_in = last_ff; cp_in = cp_ff; dn_in = dn_ff;
      ni_in = ni_ff; dig_in = dig_ff;
      dctl = '0;
      wr_en = 1'b0; wr_addr = AW'(clr_ff[AW-1:0]); wr_data = 8'd0;
      clr_in = clr_ff;
      n = 5'd0; b = req_data; hc = hcnt_ff; cp = 31'd0; emit = 1'b0;
      if (clearing) begin
         wr_en = 1'b1;
         clr_in = clr_ff + 1'b1;
      end
      case (state_ff)
         u2h_pkg::ST_IDLE: begin
            if (take && req_action) begin
               if (32'(req_code) < ENTITY_COUNT && 32'(req_pos) < NAME_LEN) begin
                  wr_en = 1'b1;
                  wr_addr = AW'(32'(req_code) * NAME_LEN + 32'(req_pos));
                  wr_data = req_data;
               end
            end else if (take) begin
               if (tag_ff) begin
                  q_in[0] = b; n = 5'd1;
                  if (b == 8'h3E) tag_in = 1'b0;
               end else if (hcnt_ff != 3'd0) begin
                  if (b[7]) begin
                     if (hcnt_ff < 3'd5) held_in[hcnt_ff] = b;
                     hc = hcnt_ff + 3'd1;
                     acc_in = {acc_ff[24:0], 6'd0} | 31'(b[6:0]);
                     hcnt_in = hc;
                     if (hc >= slen_ff) begin
                        cp = {acc_ff[24:0], 6'd0} | 31'(b[6:0]);
                        hcnt_in = 3'd0; slen_in = 3'd0; acc_in = 31'd0;
                        emit = 1'b1;
                     end
                  end else begin
                     for (int i = 0; i < 5; i++)
                        if (3'(i) < hcnt_ff) q_in[i] = held_ff[i];
                     q_in[5'(hcnt_ff)] = b;
                     n = 5'(hcnt_ff) + 5'd1;
                     hcnt_in = 3'd0; slen_in = 3'd0; acc_in = 31'd0;
                  end
               end else if (b == 8'h3C) begin
                  q_in[0] = b; n = 5'd1; tag_in = 1'b1;
               end else if (b == 8'h7E) begin
                  chg_in = 1'b1;
                  q_in[0] = 8'h26; q_in[1] = 8'h74; q_in[2] = 8'h69; q_in[3] = 8'h6C;
                  q_in[4] = 8'h64; q_in[5] = 8'h65; q_in[6] = 8'h3B; n = 5'd7;
               end else if (b >= 8'hC0 && b <= 8'hFD) begin
                  held_in[0] = b; hcnt_in = 3'd1;
                  if (b < 8'hE0) begin slen_in = 3'd2; acc_in = 31'(b[4:0]); end
                  else if (b < 8'hF0) begin slen_in = 3'd3; acc_in = 31'(b[3:0]); end
                  else if (b < 8'hF8) begin slen_in = 3'd4; acc_in = 31'(b[2:0]); end
                  else if (b < 8'hFC) begin slen_in = 3'd5; acc_in = 31'(b[1:0]); end
                  else begin slen_in = 3'd6; acc_in = 31'(b[0]); end
               end else begin
                  q_in[0] = b; n = 5'd1;
               end
               if (req_last && !emit && hcnt_in != 3'd0) begin
                  for (int i = 0; i < 5; i++)
                     if (3'(i) < hcnt_in) q_in[5'(i) + n] = held_in[i];
                  n = n + 5'(hcnt_in);
               end
               last_in = req_last;
               qi_in = 5'd0; qn_in = n;
               if (emit) begin
                  chg_in = 1'b1;
                  q_in[0] = 8'h26; qn_in = 5'd1; cp_in = cp; ni_in = 4'd0;
                  state_in = u2h_pkg::ST_RDWT;
               end else if (n != 5'd0) begin
                  state_in = u2h_pkg::ST_EMIT;
               end else if (req_last) begin
                  tag_in = 1'b0; chg_in = 1'b0; hcnt_in = 3'd0; slen_in = 3'd0;
                  acc_in = 31'd0;
               end
            end
         end
         u2h_pkg::ST_RDWT: begin
            state_in = u2h_pkg::ST_NAME;
         end
         u2h_pkg::ST_NAME: begin
            if (32'(cp_ff) < ENTITY_COUNT && !(ni_ff == 4'd0 && rd_data_ff == 8'd0)
                && 32'(ni_ff) < NMAX && rd_data_ff != 8'd0) begin
               q_in[qn_ff] = rd_data_ff; qn_in = qn_ff + 5'd1;
               ni_in = ni_ff + 4'd1;
               state_in = u2h_pkg::ST_RDWT;
            end else if (32'(cp_ff) < ENTITY_COUNT && ni_ff != 4'd0) begin
               q_in[qn_ff] = 8'h3B; qn_in = qn_ff + 5'd1;
               state_in = u2h_pkg::ST_EMIT;
            end else begin
               q_in[1] = 8'h23; qn_in = 5'd2; dn_in = 4'd0;
               dctl.start = 1'b1; dctl.value = cp_ff;
               state_in = u2h_pkg::ST_DIV;
            end
         end
         u2h_pkg::ST_DIV: begin
            if (dsts.done) begin
               dig_in[dn_ff] = 8'h30 + 8'(dsts.digit);
               dn_in = dn_ff + 4'd1;
               if (dsts.zero || dn_ff == 4'd9) begin
                  for (int i = 0; i < 10; i++)
                     if (4'(i) <= dn_ff) q_in[5'd2 + 5'(i)] = (i == 0) ?
                        8'h30 + 8'(dsts.digit) : dig_ff[dn_ff - 4'(i)];
                  q_in[5'd3 + 5'(dn_ff)] = 8'h3B;
                  qn_in = 5'd4 + 5'(dn_ff);
                  state_in = u2h_pkg::ST_EMIT;
               end else begin
                  dctl.start = 1'b1;
                  dctl.value = dsts.quot;
               end
            end
         end
         u2h_pkg::ST_EMIT: begin
            if (rsp.ready) begin
               qi_in = qi_ff + 5'd1;
               if (qi_ff == qn_ff - 5'd1) begin
                  state_in = u2h_pkg::ST_IDLE;
                  if (last_ff) begin
                     tag_in = 1'b0; chg_in = 1'b0; hcnt_in = 3'd0; slen_in = 3'd0;
                     acc_in = 31'd0;
                  end
               end
            end
         end
         default: state_in = u2h_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) names[wr_addr] <= wr_data;
      rd_data_ff <= names[rd_addr];
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in; q_ff <= q_in; qn_ff <= qn_in; qi_ff <= qi_in;
      last_ff <= last_in; dn_ff <= dn_in; ni_ff <= ni_in; dig_ff <= dig_in;
      cp_ff <= cp_in;
      if (reset) begin
         state_ff <= u2h_pkg::ST_IDLE;
         tag_ff <= 1'b0; chg_ff <= 1'b0; hcnt_ff <= 3'd0; slen_ff <= 3'd0;
         clr_ff <= '0; acc_ff <= 31'd0;
      end else begin
         state_ff <= state_in;
         tag_ff <= tag_in; chg_ff <= chg_in; hcnt_ff <= hcnt_in; slen_ff <= slen_in;
         clr_ff <= clr_in; acc_ff <= acc_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while emitting");
   a_held_max: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= 3'd5) else $error("held overflow");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("emit dropped");
endmodule
